>>> sv/stb_pkg.sv
package stb_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int HIT_IDX_W   = $clog2(MAX_RESULTS);
  localparam int HIT_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    CMD_ARM    = 3'd0,
    CMD_DISARM = 3'd1,
    CMD_REARM  = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_ZERO      = 3'd1,
    STS_ARMED     = 3'd2,
    STS_BAD_RATE  = 3'd3,
    STS_TOO_LARGE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SWEEP,
    ST_EMIT
  } state_e;

endpackage

>>> sv/stb_slot_ram.sv
module stb_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 36,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] data_q;
  logic             hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    data_q <= mem[raddr_i];
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      hit_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = hit_q ? data_q : '0;

endmodule

>>> sv/software_timer_bank.sv
// Slot commands: one command at a time; the slot is read in ST_READ and the result
// word is loaded in ST_EXEC; no new word is taken until the result word is loaded.
// Tick: the sweep reads every slot, one slot per cycle, through the single RAM read
// port; then come the result words, one per cycle while out_stall_i is low (up to 16
// expiries). A tick of a bad rate takes the command path through ST_READ and ST_EXEC.
// Reset: all slots read as zero through per-entry valid bits, no clearing pass;
// the block comes out of reset idle and ready to accept a word.
module software_timer_bank #(
  parameter int NUM_TIMERS   = 16,
  parameter int NUM_RATES    = 2,
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [1:0]  rate_i,
  input  logic [31:0] n_ticks_i,
  input  logic [31:0] reload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        was_flag_o,
  output logic        expired_valid_o,
  output logic [3:0]  expired_slot_o,
  output logic        rate_idle_o,
  output logic        last_o
);
  import stb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam logic [31:0] CTR_MAX = (COUNTER_BITS < 32) ?
      32'((64'd1 << COUNTER_BITS) - 64'd1) : 32'hFFFF_FFFF;
  localparam logic [2:0] NRATES = 3'(NUM_RATES);
  localparam logic [6:0] NSLOTS = 7'(NUM_TIMERS);
  localparam logic [IDX_W:0] SWEEP_END = (IDX_W + 1)'(NUM_TIMERS);

  typedef struct packed {
    logic                    disarmed;
    logic                    linked;
    logic [1:0]              rate;
    logic [COUNTER_BITS-1:0] reload;
    logic [COUNTER_BITS-1:0] count;
  } entry_t;

  function automatic logic too_large(input logic [31:0] v);
    return (COUNTER_BITS < 32) && (v >= CTR_MAX);
  endfunction

  state_e state_q, state_d;

  logic [2:0]  cmd_q;
  logic [3:0]  slot_q;
  logic [1:0]  rate_q;
  logic [31:0] nt_q;
  logic [31:0] rl_q;

  logic [IDX_W:0]   sw_q, sw_d;
  logic             p_valid_q, p_valid_d;
  logic [IDX_W-1:0] p_idx_q, p_idx_d;

  logic [3:0]           hit_q [MAX_RESULTS];
  logic [HIT_CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [HIT_IDX_W-1:0] emit_q, emit_d;
  logic                 hit_push;

  logic [CNT_W-1:0] lcnt_q [NUM_RATES];
  logic [CNT_W-1:0] lcnt_d [NUM_RATES];

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry, new_entry;

  logic       out_valid_q;
  logic [2:0] status_q, status_d;
  logic       wf_q, wf_d;
  logic       ev_q, ev_d;
  logic [3:0] es_q, es_d;
  logic       idle_q, idle_d;
  logic       last_q, last_d;
  logic       load_out;

  logic       accept;
  logic       out_free;
  logic [6:0] slot_x;
  logic [6:0] pidx_x;
  logic       slot_ok;
  logic       rate_ok;
  logic       emit_last;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign slot_x    = 7'(slot_q);
  assign pidx_x    = 7'(p_idx_q);
  assign slot_ok   = slot_x < NSLOTS;
  assign rate_ok   = {1'b0, rate_q} < NRATES;
  assign emit_last = (hit_cnt_q == '0) ||
                     ((HIT_CNT_W'(emit_q) + HIT_CNT_W'(1)) == hit_cnt_q);

  stb_slot_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH ($bits(entry_t)),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (new_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_TICK && {1'b0, rate_i} < NRATES) begin
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (sw_q == SWEEP_END) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic wr;
    wr        = 1'b0;
    wr_addr   = slot_x[IDX_W-1:0];
    rd_addr   = slot_x[IDX_W-1:0];
    new_entry = rd_entry;
    sw_d      = sw_q;
    p_valid_d = 1'b0;
    p_idx_d   = p_idx_q;
    hit_cnt_d = hit_cnt_q;
    hit_push  = 1'b0;
    emit_d    = emit_q;
    load_out  = 1'b0;
    status_d  = STS_OK;
    wf_d      = 1'b0;
    ev_d      = 1'b0;
    es_d      = '0;
    last_d    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        sw_d      = '0;
        hit_cnt_d = '0;
        emit_d    = '0;
      end
      ST_READ: ;
      ST_EXEC: begin
        load_out = out_free;
        if (cmd_q == CMD_TICK) begin
          status_d = STS_BAD_RATE;
        end else if (slot_ok) begin
          case (cmd_q)
            CMD_ARM: begin
              if (too_large(nt_q) || too_large(rl_q)) begin
                status_d = STS_TOO_LARGE;
              end else if (nt_q == '0) begin
                status_d = STS_ZERO;
              end else if (rd_entry.count != '0) begin
                status_d = STS_ARMED;
              end else if (!rate_ok) begin
                status_d = STS_BAD_RATE;
              end else begin
                new_entry.count  = nt_q[COUNTER_BITS-1:0];
                new_entry.reload = rl_q[COUNTER_BITS-1:0];
                new_entry.rate   = rate_q;
                new_entry.linked = 1'b1;
                wr = 1'b1;
              end
            end
            CMD_DISARM: begin
              wr = 1'b1;
              if (rd_entry.count != '0) begin
                wf_d               = 1'b1;
                new_entry.disarmed = 1'b1;
                new_entry.count    = '0;
              end else begin
                new_entry.disarmed = 1'b0;
              end
            end
            CMD_REARM: begin
              if (too_large(nt_q)) begin
                status_d = STS_TOO_LARGE;
              end else if (nt_q == '0) begin
                status_d = STS_ZERO;
              end else if ({1'b0, rd_entry.rate} >= NRATES) begin
                status_d = STS_BAD_RATE;
              end else begin
                wf_d             = |rd_entry.count;
                new_entry.count  = nt_q[COUNTER_BITS-1:0];
                new_entry.linked = 1'b1;
                wr = 1'b1;
              end
            end
            CMD_QUERY: begin
              wf_d               = rd_entry.disarmed;
              new_entry.disarmed = 1'b1;
              wr = 1'b1;
            end
            default: ;
          endcase
        end
        wr = wr && out_free;
      end
      ST_SWEEP: begin
        rd_addr = sw_q[IDX_W-1:0];
        wr_addr = p_idx_q;
        if (sw_q != SWEEP_END) begin
          sw_d      = sw_q + (IDX_W + 1)'(1);
          p_valid_d = 1'b1;
          p_idx_d   = sw_q[IDX_W-1:0];
        end
        if (p_valid_q && rd_entry.linked && rd_entry.rate == rate_q) begin
          wr = 1'b1;
          if (rd_entry.count == '0) begin
            new_entry.linked = 1'b0;
          end else if (rd_entry.count == COUNTER_BITS'(1)) begin
            if (rd_entry.reload != '0) begin
              new_entry.count = rd_entry.reload;
            end else begin
              new_entry.count  = '0;
              new_entry.linked = 1'b0;
            end
            if (hit_cnt_q < HIT_CNT_W'(MAX_RESULTS)) begin
              hit_push  = 1'b1;
              hit_cnt_d = hit_cnt_q + HIT_CNT_W'(1);
            end
          end else begin
            new_entry.count = rd_entry.count - COUNTER_BITS'(1);
          end
        end
      end
      ST_EMIT: begin
        load_out = out_free;
        last_d   = emit_last;
        if (hit_cnt_q != '0) begin
          ev_d = 1'b1;
          es_d = hit_q[emit_q];
          if (out_free) begin
            emit_d = emit_q + HIT_IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
    wr_en = wr;
  end

  // per-rate count of linked slots
  always_comb begin
    logic inc, dec;
    for (int r = 0; r < NUM_RATES; r++) begin
      inc = wr_en && new_entry.linked && (new_entry.rate == 2'(r));
      dec = wr_en && rd_entry.linked && (rd_entry.rate == 2'(r));
      lcnt_d[r] = lcnt_q[r] + CNT_W'(inc) - CNT_W'(dec);
    end
  end

  always_comb begin
    idle_d = 1'b1;
    for (int r = 0; r < NUM_RATES; r++) begin
      if (rate_q == 2'(r) && lcnt_d[r] != '0) begin
        idle_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sw_q        <= '0;
      p_valid_q   <= 1'b0;
      hit_cnt_q   <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NUM_RATES; r++) begin
        lcnt_q[r] <= '0;
      end
    end else begin
      state_q   <= state_d;
      sw_q      <= sw_d;
      p_valid_q <= p_valid_d;
      hit_cnt_q <= hit_cnt_d;
      emit_q    <= emit_d;
      lcnt_q    <= lcnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      rate_q <= rate_i;
      nt_q   <= n_ticks_i;
      rl_q   <= reload_i;
    end
    p_idx_q <= p_idx_d;
    if (hit_push) begin
      hit_q[hit_cnt_q[HIT_IDX_W-1:0]] <= pidx_x[3:0];
    end
    if (load_out) begin
      status_q <= status_d;
      wf_q     <= wf_d;
      ev_q     <= ev_d;
      es_q     <= es_d;
      idle_q   <= idle_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign was_flag_o      = wf_q;
  assign expired_valid_o = ev_q;
  assign expired_slot_o  = es_q;
  assign rate_idle_o     = idle_q;
  assign last_o          = last_q;

endmodule
